// File: design/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and constants of the telemetry packet checker.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int COUNT_W   = 6;

   localparam logic [CSR_IDX_W-1:0] REG_BATTERY_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_MIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_MAX    = 2'd2;

   localparam logic [31:0] BATTERY_MAX_RST = 32'd10000;
   localparam logic [31:0] TEMP_MIN_RST    = 32'hFFFF_D8F0;   // -10000
   localparam logic [31:0] TEMP_MAX_RST    = 32'd15000;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [COUNT_W-1:0] HASHED_LEN = 6'd27;
   localparam logic [COUNT_W-1:0] PACKET_LEN = 6'd31;
   localparam logic [COUNT_W-1:0] COUNT_SAT  = 6'd32;

   localparam logic [7:0] MAGIC_0 = 8'h54;   // 'T'
   localparam logic [7:0] MAGIC_1 = 8'h4D;   // 'M'
   localparam logic [7:0] VERSION = 8'h01;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SIZE     = 3'd1;
   localparam logic [2:0] ST_MAGIC    = 3'd2;
   localparam logic [2:0] ST_VERSION  = 3'd3;
   localparam logic [2:0] ST_CHECKSUM = 3'd4;
   localparam logic [2:0] ST_DEVICE   = 3'd5;
   localparam logic [2:0] ST_BATTERY  = 3'd6;
   localparam logic [2:0] ST_TEMP     = 3'd7;

   typedef struct packed {
      logic        [31:0] battery_max_mv;
      logic signed [31:0] temp_min_centi;
      logic signed [31:0] temp_max_centi;
   } cfg_type;

   typedef struct packed {
      logic        [2:0]  status;
      logic        [31:0] device_id;
      logic        [31:0] sequence_res;
      logic signed [31:0] temperature_centi;
      logic        [31:0] battery_mv;
      logic        [63:0] timestamp_s;
   } rsp_type;

endpackage

// File: design/tpc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_req_if
// Byte stream channel: one datagram byte per beat, flag on the final byte.
// ----------------------------------------------------------------------------
interface tpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/tpc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_rsp_if
// Result channel: one beat per datagram with status and decoded fields.
// ----------------------------------------------------------------------------
interface tpc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  status;
   logic        [31:0] device_id;
   logic        [31:0] sequence_res;
   logic signed [31:0] temperature_centi;
   logic        [31:0] battery_mv;
   logic        [63:0] timestamp_s;

   modport source (output valid, output status, output device_id, output sequence_res,
                   output temperature_centi, output battery_mv, output timestamp_s,
                   input ready);
   modport sink   (input valid, input status, input device_id, input sequence_res,
                   input temperature_centi, input battery_mv, input timestamp_s,
                   output ready);
endinterface

// File: design/tpc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_csr_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface tpc_csr_if;
   import tpc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: design/tpc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_csr
// Limit registers: battery maximum and temperature window.
// ----------------------------------------------------------------------------
module tpc_csr (
   input  logic             clock,
   input  logic             reset,
   tpc_csr_if.sink          csr_chan,
   output tpc_pkg::cfg_type cfg
);
   import tpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_BATTERY_MAX: cfg_in.battery_max_mv = csr_chan.wdata;
            REG_TEMP_MIN:    cfg_in.temp_min_centi = $signed(csr_chan.wdata);
            REG_TEMP_MAX:    cfg_in.temp_max_centi = $signed(csr_chan.wdata);
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_max_mv <= BATTERY_MAX_RST;
         cfg_ff.temp_min_centi <= $signed(TEMP_MIN_RST);
         cfg_ff.temp_max_centi <= $signed(TEMP_MAX_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/tpc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_parser
// Input register, per-datagram state (count, FNV-1a hash, field shift
// registers) and the status checks evaluated on the final byte.
// ----------------------------------------------------------------------------
module tpc_parser (
   input  logic             clock,
   input  logic             reset,
   tpc_req_if.sink          req_chan,
   input  tpc_pkg::cfg_type cfg,
   input  logic             out_free,
   output logic             res_valid,
   output tpc_pkg::rsp_type res
);
   import tpc_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       take;
   logic       req_ready;

   // datagram state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        hash_ff, hash_in;
   logic               magic_bad_ff, magic_bad_in;
   logic               version_bad_ff, version_bad_in;
   logic [31:0]        device_ff, device_in;
   logic [31:0]        seq_ff, seq_in;
   logic [31:0]        temp_ff, temp_in;
   logic [31:0]        batt_ff, batt_in;
   logic [63:0]        ts_ff, ts_in;
   logic [31:0]        csum_ff, csum_in;

   logic [COUNT_W-1:0] count_nx;
   logic [31:0]        hash_x;
   logic [2:0]         status;

   // a non-final beat never needs the result slot
   assign take      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || take;
   assign req_chan.ready = req_ready;
   assign in_valid_in = req_ready ? req_chan.valid : in_valid_ff;

   assign hash_x = hash_ff ^ {24'd0, in_data_ff};

   always_comb begin
      count_nx       = (count_ff == COUNT_SAT) ? count_ff : count_ff + 6'd1;
      hash_in        = hash_ff;
      magic_bad_in   = magic_bad_ff;
      version_bad_in = version_bad_ff;
      device_in      = device_ff;
      seq_in         = seq_ff;
      temp_in        = temp_ff;
      batt_in        = batt_ff;
      ts_in          = ts_ff;
      csum_in        = csum_ff;

      if (count_ff < HASHED_LEN) begin
         hash_in = hash_x * FNV_PRIME;
      end

      case (count_ff) inside
         6'd0:           magic_bad_in   = magic_bad_ff | (in_data_ff != MAGIC_0);
         6'd1:           magic_bad_in   = magic_bad_ff | (in_data_ff != MAGIC_1);
         6'd2:           version_bad_in = (in_data_ff != VERSION);
         [6'd3:6'd6]:    device_in      = {device_ff[23:0], in_data_ff};
         [6'd7:6'd10]:   seq_in         = {seq_ff[23:0], in_data_ff};
         [6'd11:6'd14]:  temp_in        = {temp_ff[23:0], in_data_ff};
         [6'd15:6'd18]:  batt_in        = {batt_ff[23:0], in_data_ff};
         [6'd19:6'd26]:  ts_in          = {ts_ff[55:0], in_data_ff};
         [6'd27:6'd30]:  csum_in        = {csum_ff[23:0], in_data_ff};
         default: ;      // overlong datagram: counted, not stored
      endcase

      // at a full-length final beat the hash is already complete, so hash_ff
      // is compared rather than the multiplier output
      if (count_nx != PACKET_LEN) begin
         status = ST_SIZE;
      end else if (magic_bad_in) begin
         status = ST_MAGIC;
      end else if (version_bad_in) begin
         status = ST_VERSION;
      end else if (csum_in != hash_ff) begin
         status = ST_CHECKSUM;
      end else if (device_in == 32'd0) begin
         status = ST_DEVICE;
      end else if (batt_in > cfg.battery_max_mv) begin
         status = ST_BATTERY;
      end else if (($signed(temp_in) < cfg.temp_min_centi) ||
                   ($signed(temp_in) > cfg.temp_max_centi)) begin
         status = ST_TEMP;
      end else begin
         status = ST_OK;
      end

      count_in = count_nx;
      if (in_last_ff) begin
         count_in       = '0;
         hash_in        = FNV_BASIS;
         magic_bad_in   = 1'b0;
         version_bad_in = 1'b0;
      end
   end

   assign res_valid = take && in_last_ff;

   always_comb begin
      res.status = status;
      if (status == ST_SIZE || status == ST_MAGIC || status == ST_VERSION ||
          status == ST_CHECKSUM) begin
         res.device_id         = '0;
         res.sequence_res      = '0;
         res.temperature_centi = '0;
         res.battery_mv        = '0;
         res.timestamp_s       = '0;
      end else begin
         res.device_id         = device_in;
         res.sequence_res      = seq_in;
         res.temperature_centi = $signed(temp_in);
         res.battery_mv        = batt_in;
         res.timestamp_s       = ts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         hash_ff        <= FNV_BASIS;
         magic_bad_ff   <= 1'b0;
         version_bad_ff <= 1'b0;
      end else if (take) begin
         count_ff       <= count_in;
         hash_ff        <= hash_in;
         magic_bad_ff   <= magic_bad_in;
         version_bad_ff <= version_bad_in;
      end
   end

   // field registers are fully refilled before any full-length datagram reads them
   always_ff @(posedge clock) begin
      if (take) begin
         device_ff <= device_in;
         seq_ff    <= seq_in;
         temp_ff   <= temp_in;
         batt_ff   <= batt_in;
         ts_ff     <= ts_in;
         csum_ff   <= csum_in;
      end
   end

endmodule

// File: design/tpc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_out_stage
// Result register holding one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module tpc_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   input  tpc_pkg::rsp_type res,
   output logic             out_free,
   tpc_rsp_if.source        rsp_chan
);
   import tpc_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_ff.status;
   assign rsp_chan.device_id         = rsp_ff.device_id;
   assign rsp_chan.sequence_res      = rsp_ff.sequence_res;
   assign rsp_chan.temperature_centi = rsp_ff.temperature_centi;
   assign rsp_chan.battery_mv        = rsp_ff.battery_mv;
   assign rsp_chan.timestamp_s       = rsp_ff.timestamp_s;

endmodule

// File: design/telemetry_packet_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_checker_core
// Checks 31-byte telemetry datagrams (magic, version, FNV-1a checksum,
// device, battery and temperature limits) and decodes their fields.
// ----------------------------------------------------------------------------
// Bytes stream in on req_chan at one beat per clock while no stall holds them,
// with last_byte on the final byte of each datagram; each datagram yields
// exactly one beat on rsp_chan, through the input register and then the
// result register. The rate is set by the FNV-1a hash step, one constant
// multiply per byte. Backpressure on rsp_chan stalls req_chan only when a
// final byte meets a full result register. Limits are written through
// csr_chan (0 battery max, 1 temp min, 2 temp max); the user must write
// them only while no datagram is in flight, as the block does not enforce it.
module telemetry_packet_checker_core (
   input  logic      clock,
   input  logic      reset,
   tpc_req_if.sink   req_chan,
   tpc_rsp_if.source rsp_chan,
   tpc_csr_if.sink   csr_chan
);
   import tpc_pkg::*;

   cfg_type cfg;
   rsp_type res;
   logic    res_valid;
   logic    out_free;

   tpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tpc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   tpc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: sim/tb_telemetry_packet_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telemetry_packet_checker_core
// Self-checking bench: streams datagrams byte by byte, predicts each verdict.
// ----------------------------------------------------------------------------
// A local model tracks the byte count, FNV-1a hash, header checks and field
// shift registers. It queues one expected verdict per final byte. Directed
// datagrams hit every status code, length corner and limit extreme. Random
// traffic (mostly well-formed datagrams with random corruption, plus noise)
// runs under several limit settings, mostly with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_telemetry_packet_checker_core;
   import tpc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic clock = 1'b0;
   logic reset;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tpc_req_if req_if ();
   tpc_rsp_if rsp_if ();
   tpc_csr_if csr_if ();

   telemetry_packet_checker_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Model of the limit registers
   logic        [31:0] lim_batt;
   logic signed [31:0] lim_tmin;
   logic signed [31:0] lim_tmax;

   // Model of the per-datagram parse state
   logic [COUNT_W-1:0] acc_count;
   logic [31:0]        acc_hash;
   logic               acc_magic_bad;
   logic               acc_version_bad;
   logic [31:0]        acc_device;
   logic [31:0]        acc_sequence;
   logic [31:0]        acc_temp;
   logic [31:0]        acc_battery;
   logic [63:0]        acc_stamp;
   logic [31:0]        acc_checksum;

   rsp_type    pending_verdicts[$];
   logic [7:0] frame_buf[$];

   int  bytes_sent;
   int  datagrams_sent;
   int  verdicts_seen;
   int  mismatch_count;
   int  cycle_count;
   int  status_hits[8];
   bit  req_gaps_on = 1'b1;
   bit  rsp_stall_on = 1'b1;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   task automatic clear_parse_state();
      acc_count       = '0;
      acc_hash        = FNV_BASIS;
      acc_magic_bad   = 1'b0;
      acc_version_bad = 1'b0;
      acc_device      = '0;
      acc_sequence    = '0;
      acc_temp        = '0;
      acc_battery     = '0;
      acc_stamp       = '0;
      acc_checksum    = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      rsp_type            verdict;
      logic [COUNT_W-1:0] pos;
      pos = acc_count;
      if (pos < HASHED_LEN)
         acc_hash = (acc_hash ^ {24'd0, b}) * FNV_PRIME;
      if (pos == 0) begin
         if (b != MAGIC_0) acc_magic_bad = 1'b1;
      end else if (pos == 1) begin
         if (b != MAGIC_1) acc_magic_bad = 1'b1;
      end else if (pos == 2) begin
         acc_version_bad = (b != VERSION);
      end else if (pos <= 6) begin
         acc_device = {acc_device[23:0], b};
      end else if (pos <= 10) begin
         acc_sequence = {acc_sequence[23:0], b};
      end else if (pos <= 14) begin
         acc_temp = {acc_temp[23:0], b};
      end else if (pos <= 18) begin
         acc_battery = {acc_battery[23:0], b};
      end else if (pos <= 26) begin
         acc_stamp = {acc_stamp[55:0], b};
      end else if (pos <= 30) begin
         acc_checksum = {acc_checksum[23:0], b};
      end
      if (acc_count < COUNT_SAT)
         acc_count = acc_count + 1'b1;
      if (fin) begin
         verdict = '0;
         if (acc_count != PACKET_LEN)
            verdict.status = ST_SIZE;
         else if (acc_magic_bad)
            verdict.status = ST_MAGIC;
         else if (acc_version_bad)
            verdict.status = ST_VERSION;
         else if (acc_checksum != acc_hash)
            verdict.status = ST_CHECKSUM;
         else if (acc_device == 32'd0)
            verdict.status = ST_DEVICE;
         else if (acc_battery > lim_batt)
            verdict.status = ST_BATTERY;
         else if ($signed(acc_temp) < lim_tmin || $signed(acc_temp) > lim_tmax)
            verdict.status = ST_TEMP;
         else
            verdict.status = ST_OK;
         // decode failures report zeroed fields
         if (verdict.status == ST_OK || verdict.status >= ST_DEVICE) begin
            verdict.device_id         = acc_device;
            verdict.sequence_res      = acc_sequence;
            verdict.temperature_centi = acc_temp;
            verdict.battery_mv        = acc_battery;
            verdict.timestamp_s       = acc_stamp;
         end
         pending_verdicts.insert(pending_verdicts.size(), verdict);
         datagrams_sent++;
         clear_parse_state();
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result beat with no datagram pending, status %0d",
                        $realtime, rsp_if.status);
         end else begin
            want = pending_verdicts.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_if.status));
            check_field("device_id", 64'(want.device_id), 64'(rsp_if.device_id));
            check_field("sequence_res", 64'(want.sequence_res), 64'(rsp_if.sequence_res));
            check_field("temperature_centi", 64'(want.temperature_centi),
                        64'(rsp_if.temperature_centi));
            check_field("battery_mv", 64'(want.battery_mv), 64'(rsp_if.battery_mv));
            check_field("timestamp_s", want.timestamp_s, rsp_if.timestamp_s);
            status_hits[want.status]++;
            verdicts_seen++;
         end
      end
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= !(rsp_stall_on && $urandom_range(99) < 29);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_verdicts.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_beat(input logic [7:0] b, input logic fin);
      while (req_gaps_on && $urandom_range(99) < 29) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= fin;
      do @(posedge clock); while (!req_if.ready);
      parse_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int k;
      for (k = 0; k < frame_buf.size(); k++)
         send_beat(frame_buf[k], k == frame_buf.size() - 1);
   endtask

   // builds a well-formed 31-byte datagram with a matching checksum
   task automatic fill_frame(input logic [31:0] dev, input logic [31:0] seq,
                             input logic [31:0] temp, input logic [31:0] batt,
                             input logic [63:0] stamp);
      logic [31:0] h;
      int          k;
      frame_buf = {MAGIC_0, MAGIC_1, VERSION};
      for (k = 3; k >= 0; k--) frame_buf.insert(frame_buf.size(), dev[k*8 +: 8]);
      for (k = 3; k >= 0; k--) frame_buf.insert(frame_buf.size(), seq[k*8 +: 8]);
      for (k = 3; k >= 0; k--) frame_buf.insert(frame_buf.size(), temp[k*8 +: 8]);
      for (k = 3; k >= 0; k--) frame_buf.insert(frame_buf.size(), batt[k*8 +: 8]);
      for (k = 7; k >= 0; k--) frame_buf.insert(frame_buf.size(), stamp[k*8 +: 8]);
      h = FNV_BASIS;
      for (k = 0; k < frame_buf.size(); k++)
         h = (h ^ {24'd0, frame_buf[k]}) * FNV_PRIME;
      for (k = 3; k >= 0; k--) frame_buf.insert(frame_buf.size(), h[k*8 +: 8]);
   endtask

   task automatic send_fields(input logic [31:0] dev, input logic [31:0] seq,
                              input logic [31:0] temp, input logic [31:0] batt,
                              input logic [63:0] stamp);
      fill_frame(dev, seq, temp, batt, stamp);
      send_frame();
   endtask

   // stop sending and wait out every outstanding verdict
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_BATTERY_MAX: lim_batt = val;
         REG_TEMP_MIN:    lim_tmin = val;
         REG_TEMP_MAX:    lim_tmax = val;
         default: ;
      endcase
   endtask

   // only called with the block idle
   task automatic set_limits(input logic [31:0] batt, input logic [31:0] tmin,
                             input logic [31:0] tmax);
      csr_beat(REG_BATTERY_MAX, batt);
      csr_beat(REG_TEMP_MIN, tmin);
      csr_beat(REG_TEMP_MAX, tmax);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_battery();
      case ($urandom_range(5))
         0:       return lim_batt;
         1:       return lim_batt + 1;
         2:       return lim_batt - 1;
         3:       return 32'd0;
         4:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_temp();
      case ($urandom_range(7))
         0:       return lim_tmin;
         1:       return lim_tmin - 1;
         2:       return lim_tmax;
         3:       return lim_tmax + 1;
         4:       return 32'h8000_0000;
         5:       return 32'h7FFF_FFFF;
         6:       return $urandom_range(40000) - 20000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_datagram();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 65) begin
         fill_frame(($urandom_range(7) == 0) ? 32'd0 : $urandom, $urandom, pick_temp(),
                    pick_battery(), {$urandom, $urandom});
         case ($urandom_range(11))
            0: frame_buf[0] = 8'($urandom);
            1: frame_buf[1] = 8'($urandom);
            2: frame_buf[2] = 8'($urandom_range(3));
            3: frame_buf[27 + $urandom_range(3)] ^= 8'd1 << $urandom_range(7);
            4: repeat ($urandom_range(1, 6)) void'(frame_buf.pop_back());
            5: repeat ($urandom_range(1, 6)) frame_buf.insert(frame_buf.size(), 8'($urandom));
            default: ;
         endcase
      end else begin
         // noise: random length, sometimes behind a valid header
         n = (kind < 88) ? $urandom_range(1, 31) : $urandom_range(32, 70);
         frame_buf = {};
         if ($urandom_range(1)) frame_buf = {MAGIC_0, MAGIC_1, VERSION};
         while (frame_buf.size() < n) frame_buf.insert(frame_buf.size(), 8'($urandom));
      end
      send_frame();
   endtask

   task automatic run_traffic(input int n_bytes);
      int b0;
      int d0;
      b0 = bytes_sent;
      d0 = datagrams_sent;
      while (bytes_sent - b0 < n_bytes || datagrams_sent - d0 < 2)
         send_random_datagram();
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_status_codes();
      send_fields(32'd1, 32'd2, 32'd2500, 32'd3700, 64'd1);
      fill_frame(32'd1, 32'd2, 32'd0, 32'd0, 64'd0);
      frame_buf[0] = 8'h55;
      send_frame();
      fill_frame(32'd1, 32'd2, 32'd0, 32'd0, 64'd0);
      frame_buf[1] = 8'h00;
      send_frame();
      fill_frame(32'd1, 32'd2, 32'd0, 32'd0, 64'd0);
      frame_buf[2] = 8'h00;
      send_frame();
      fill_frame(32'd1, 32'd2, 32'd0, 32'd0, 64'd0);
      frame_buf[2] = 8'hFF;
      send_frame();
      // bad magic outranks bad version
      fill_frame(32'd1, 32'd2, 32'd0, 32'd0, 64'd0);
      frame_buf[0] = 8'h00;
      frame_buf[2] = 8'h00;
      send_frame();
      fill_frame(32'd5, 32'd6, 32'd100, 32'd200, 64'd7);
      frame_buf[30] ^= 8'h80;
      send_frame();
      send_fields(32'd0, 32'd9, 32'd100, 32'd200, 64'd3);
      send_fields(32'd1, 32'd9, 32'd100, BATTERY_MAX_RST + 1, 64'd3);
      send_fields(32'd1, 32'd9, TEMP_MIN_RST - 1, 32'd200, 64'd3);
      send_fields(32'd1, 32'd9, TEMP_MAX_RST + 1, 32'd200, 64'd3);
      send_fields(32'd1, 32'd9, TEMP_MIN_RST, BATTERY_MAX_RST, 64'd3);
      send_fields(32'd1, 32'd9, TEMP_MAX_RST, 32'd0, 64'd3);
   endtask

   task automatic test_length_cases();
      frame_buf = {MAGIC_0};
      send_frame();
      frame_buf = {8'h00};
      send_frame();
      fill_frame(32'd1, 32'd2, 32'd3, 32'd4, 64'd5);
      void'(frame_buf.pop_back());
      send_frame();
      fill_frame(32'd1, 32'd2, 32'd3, 32'd4, 64'd5);
      frame_buf.insert(frame_buf.size(), 8'h00);
      send_frame();
      // long enough to hold the byte count at saturation
      fill_frame(32'd1, 32'd2, 32'd3, 32'd4, 64'd5);
      while (frame_buf.size() < 70) frame_buf.insert(frame_buf.size(), 8'($urandom));
      send_frame();
      send_fields(32'hDEAD_BEEF, 32'd77, 32'd1234, 32'd4100, 64'd99);
   endtask

   task automatic test_limit_extremes();
      drain_results();
      set_limits(32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_fields(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd1, 64'd0);
      drain_results();
      set_limits(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_fields(32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 64'd0);
      send_fields(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 64'd0);
      send_fields(32'd1, 32'd0, 32'd1, 32'd0, 64'd0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      set_limits(BATTERY_MAX_RST, TEMP_MIN_RST, TEMP_MAX_RST);
      run_traffic(60);
      set_limits($urandom, $urandom, $urandom);
      run_traffic(60);
      // back-to-back stretch, no gaps and no stalls
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      set_limits($urandom_range(20000), -$urandom_range(5000), $urandom_range(5000));
      run_traffic(160);
      req_gaps_on  = 1'b1;
      rsp_stall_on = 1'b1;
      set_limits(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      run_traffic(60);
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= 8'd0;
      req_if.last_byte <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= REG_BATTERY_MAX;
      csr_if.wdata     <= '0;
      lim_batt = BATTERY_MAX_RST;
      lim_tmin = TEMP_MIN_RST;
      lim_tmax = TEMP_MAX_RST;
      clear_parse_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_status_codes();
      test_length_cases();
      test_limit_extremes();
      test_random_traffic();

      drain_results();
      repeat (8) @(posedge clock);

      $display("covered %0d datagrams over %0d bytes, %0d verdicts checked, %0d mismatches",
               datagrams_sent, bytes_sent, verdicts_seen, mismatch_count);
      $display("verdicts: ok %0d size %0d magic %0d version %0d checksum %0d device %0d %s %0d %s %0d",
               status_hits[ST_OK], status_hits[ST_SIZE], status_hits[ST_MAGIC],
               status_hits[ST_VERSION], status_hits[ST_CHECKSUM], status_hits[ST_DEVICE],
               "battery", status_hits[ST_BATTERY], "temperature", status_hits[ST_TEMP]);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
